### design/ekvt_pkg.sv
// Package for the epoch keyed voter table: sizes, operation and status
// codes, and the input, result and compare-unit structs.
// No dependencies.
package ekvt_pkg;

  localparam int CAPACITY  = 8;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int KEY_WORDS = 4;
  localparam int KW_W      = $clog2(KEY_WORDS);
  localparam int KEY_DEPTH = CAPACITY * KEY_WORDS;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int EPOCH_W   = 64;
  localparam int KEY_W     = 64;

  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_LOOKUP   = 2'd1;
  localparam logic [1:0] OP_PURGE    = 2'd2;
  localparam logic [1:0] OP_CONTAINS = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key_in_w0;
    logic [KEY_W-1:0]   key_in_w1;
    logic [KEY_W-1:0]   key_in_w2;
    logic [KEY_W-1:0]   key_in_w3;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic               existed;
    logic [KEY_W-1:0]   key_out_w0;
    logic [KEY_W-1:0]   key_out_w1;
    logic [KEY_W-1:0]   key_out_w2;
    logic [KEY_W-1:0]   key_out_w3;
    logic [3:0]         entry_count;
    logic [EPOCH_W-1:0] max_epoch;
  } out_word_t;

  typedef struct packed {
    logic eq;
    logic lt;
    logic gt_best;
    logic gt_latest;
  } cmp_res_t;

endpackage

### design/ekvt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ekvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ekvt_cmp.sv
// Shared epoch compare unit: tests one candidate epoch against the request
// epoch, the best predecessor so far and the running maximum.
// Depends on ekvt_pkg.
module ekvt_cmp (
  input  logic [ekvt_pkg::EPOCH_W-1:0] cand,
  input  logic [ekvt_pkg::EPOCH_W-1:0] req_ep,
  input  logic [ekvt_pkg::EPOCH_W-1:0] best,
  input  logic [ekvt_pkg::EPOCH_W-1:0] latest,
  output ekvt_pkg::cmp_res_t           res
);

  always_comb begin
    res.eq        = (cand == req_ep);
    res.lt        = (cand < req_ep);
    res.gt_best   = (cand > best);
    res.gt_latest = (cand > latest);
  end

endmodule

### design/epoch_keyed_voter_table_core.sv
// Epoch keyed voter table: up to CAPACITY epochs, each with a 256-bit key.
// Depends on ekvt_pkg, ekvt_ram and ekvt_cmp.
// One word is handled at a time; in_ready is high only while idle. Every
// operation scans all CAPACITY epoch slots through one compare unit, one
// slot per cycle from the epoch RAM. Purge, contains and lookup misses then
// skip the key transfer; when a key is read or written, the key RAM moves
// one 64-bit key word per cycle. Results wait in an output register; the
// block holds its last step while that register is full. Slots that were
// never written are never read back.
module epoch_keyed_voter_table_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ekvt_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ekvt_pkg::out_word_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_KEY  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int IDX_W     = ekvt_pkg::IDX_W;
  localparam int KW_W      = ekvt_pkg::KW_W;
  localparam int CNT_W     = ekvt_pkg::CNT_W;
  localparam int EPOCH_W   = ekvt_pkg::EPOCH_W;
  localparam int KEY_W     = ekvt_pkg::KEY_W;

  logic [1:0]                    state_r;
  ekvt_pkg::in_word_t            req_r;
  logic [ekvt_pkg::CAPACITY-1:0] valid_r;

  logic [IDX_W-1:0]   idx_r;
  logic               issue_r;
  logic               pipe_r;
  logic [IDX_W-1:0]   cmp_idx_r;

  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic               best_vld_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [EPOCH_W-1:0] best_ep_r;
  logic               free_vld_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [EPOCH_W-1:0] latest_r;

  logic [KW_W:0]      kw_r;
  logic               kv_r;
  logic [KW_W-1:0]    kd_r;
  logic [KEY_W-1:0]   key_r [ekvt_pkg::KEY_WORDS];

  logic                out_valid_r;
  ekvt_pkg::out_word_t out_data_r;
  ekvt_pkg::out_word_t out_nxt;

  logic [EPOCH_W-1:0]  ep_rdata;
  logic [KEY_W-1:0]    key_rdata;
  logic [EPOCH_W-1:0]  cmp_a;
  ekvt_pkg::cmp_res_t  cmp;

  logic is_load, is_lookup, is_purge, is_contains;
  logic accept, scan_last, ent_valid, survive;
  logic key_rd_need, key_wr_need, ins, kw_issue, done_fire;
  logic [IDX_W-1:0]       wr_slot, rd_slot;
  logic [KW_W-1:0]        widx;
  logic                   key_we;
  logic [KEY_W-1:0]       key_wdata;
  logic [KEY_W-1:0]       in_key_word;
  logic [CNT_W-1:0]       cnt_total;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_load     = (req_r.operation == ekvt_pkg::OP_LOAD);
  assign is_lookup   = (req_r.operation == ekvt_pkg::OP_LOOKUP);
  assign is_purge    = (req_r.operation == ekvt_pkg::OP_PURGE);
  assign is_contains = (req_r.operation == ekvt_pkg::OP_CONTAINS);

  assign scan_last = pipe_r && (cmp_idx_r == IDX_W'(ekvt_pkg::CAPACITY - 1));
  assign ent_valid = valid_r[cmp_idx_r];
  assign survive   = !(is_purge && cmp.lt);

  assign key_rd_need = is_lookup && (hit_r || best_vld_r);
  assign ins         = !hit_r && free_vld_r && (is_load || (is_lookup && best_vld_r));
  assign key_wr_need = is_load ? (hit_r || free_vld_r) : ins;
  assign wr_slot     = hit_r ? hit_idx_r : free_idx_r;
  assign rd_slot     = hit_r ? hit_idx_r : best_idx_r;
  assign kw_issue    = (state_r == ST_KEY) && !kw_r[KW_W];
  assign done_fire   = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign cmp_a = (state_r == ST_DONE) ? req_r.epoch : ep_rdata;

  ekvt_cmp u_cmp (
    .cand   (cmp_a),
    .req_ep (req_r.epoch),
    .best   (best_ep_r),
    .latest (latest_r),
    .res    (cmp)
  );

  ekvt_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (ekvt_pkg::CAPACITY)
  ) u_epoch_ram (
    .clk   (clk),
    .we    (done_fire && ins),
    .waddr (free_idx_r),
    .wdata (req_r.epoch),
    .raddr (idx_r),
    .rdata (ep_rdata)
  );

  always_comb begin
    unique case (kw_r[KW_W-1:0])
      2'd0:    in_key_word = req_r.key_in_w0;
      2'd1:    in_key_word = req_r.key_in_w1;
      2'd2:    in_key_word = req_r.key_in_w2;
      default: in_key_word = req_r.key_in_w3;
    endcase
  end

  always_comb begin
    if (is_load) begin
      key_we    = kw_issue && key_wr_need;
      widx      = kw_r[KW_W-1:0];
      key_wdata = in_key_word;
    end else begin
      key_we    = (state_r == ST_KEY) && kv_r && ins;
      widx      = kd_r;
      key_wdata = key_rdata;
    end
  end

  ekvt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ekvt_pkg::KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr ({wr_slot, widx}),
    .wdata (key_wdata),
    .raddr ({rd_slot, kw_r[KW_W-1:0]}),
    .rdata (key_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state_r <= ST_KEY;
          end
        end
        ST_KEY: begin
          if ((!key_rd_need && !key_wr_need) || kw_r[KW_W]) begin
            state_r <= ST_DONE;
          end
        end
        default: begin
          if (done_fire) begin
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
  end

  // scan pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      pipe_r  <= 1'b0;
    end else begin
      pipe_r <= (state_r == ST_SCAN) && issue_r;
      if (accept) begin
        issue_r <= 1'b1;
      end else if ((state_r == ST_SCAN) && issue_r &&
                   (idx_r == IDX_W'(ekvt_pkg::CAPACITY - 1))) begin
        issue_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (accept) begin
      idx_r <= '0;
    end else if ((state_r == ST_SCAN) && issue_r) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // scan results
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r      <= 1'b0;
      best_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
      cnt_r      <= '0;
      latest_r   <= '0;
    end else if (pipe_r) begin
      if (ent_valid) begin
        if (cmp.eq) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
        end
        if (cmp.lt && (!best_vld_r || cmp.gt_best)) begin
          best_vld_r <= 1'b1;
          best_idx_r <= cmp_idx_r;
          best_ep_r  <= cmp_a;
        end
        if (survive) begin
          cnt_r <= cnt_r + 1'b1;
          if (cmp.gt_latest) begin
            latest_r <= cmp_a;
          end
        end
      end else if (!free_vld_r) begin
        free_vld_r <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (pipe_r && ent_valid && is_purge && cmp.lt) begin
      valid_r[cmp_idx_r] <= 1'b0;
    end else if (done_fire && ins) begin
      valid_r[free_idx_r] <= 1'b1;
    end
  end

  // key transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kv_r <= 1'b0;
    end else begin
      kv_r <= kw_issue && key_rd_need;
    end
  end

  always_ff @(posedge clk) begin
    kd_r <= kw_r[KW_W-1:0];
    if (accept) begin
      kw_r <= '0;
    end else if (state_r == ST_KEY) begin
      kw_r <= kw_r + 1'b1;
    end
    if ((state_r == ST_KEY) && kv_r) begin
      key_r[kd_r] <= key_rdata;
    end
  end

  // result
  assign cnt_total = CNT_W'(cnt_r + CNT_W'(ins));

  always_comb begin
    out_nxt = '0;
    priority if (is_load) begin
      if (!hit_r && !free_vld_r) begin
        out_nxt.status = ekvt_pkg::STAT_FULL;
      end
    end else if (is_lookup) begin
      if (!hit_r && !best_vld_r) begin
        out_nxt.status = ekvt_pkg::STAT_NOTFOUND;
      end else if (!hit_r && !free_vld_r) begin
        out_nxt.status = ekvt_pkg::STAT_FULL;
      end
    end else if (is_purge) begin
      if (cnt_r == '0) begin
        out_nxt.status = ekvt_pkg::STAT_EMPTY;
      end
    end else begin
      out_nxt.status = ekvt_pkg::STAT_OK;
    end
    out_nxt.found   = (is_lookup && (hit_r || best_vld_r)) || (is_contains && hit_r);
    out_nxt.existed = hit_r && !is_purge;
    if (key_rd_need) begin
      out_nxt.key_out_w0 = key_r[0];
      out_nxt.key_out_w1 = key_r[1];
      out_nxt.key_out_w2 = key_r[2];
      out_nxt.key_out_w3 = key_r[3];
    end
    out_nxt.entry_count = 4'(cnt_total);
    out_nxt.max_epoch   = (ins && cmp.gt_latest) ? req_r.epoch : latest_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

### design/ekvt_chk.sv
// Port-level checker for epoch_keyed_voter_table_core, bound to the top.
// Depends on ekvt_pkg and epoch_keyed_voter_table_core.
module ekvt_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ekvt_pkg::out_word_t out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after accepting a word");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ekvt_pkg::STAT_EMPTY) |->
      (out_data.entry_count == 4'd0) && (out_data.max_epoch == '0))
    else $error("empty status with entries left");

  a_miss_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      (out_data.key_out_w0 == '0) && (out_data.key_out_w1 == '0) &&
      (out_data.key_out_w2 == '0) && (out_data.key_out_w3 == '0))
    else $error("key returned without a find");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

endmodule

bind epoch_keyed_voter_table_core ekvt_chk u_ekvt_chk (.*);
